/* design/rrss_pkg.sv */
// Package for the round-robin slot scheduler.
// Holds operation and slot status codes and the controller/datapath link types.
// No dependencies.
package rrss_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_CHOOSE   = 2'd1;
  localparam logic [1:0] OP_ACTIVATE = 2'd2;

  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } ctrl_stat_t;

endpackage

/* design/rrss_ctrl.sv */
// Controller state machine of the round-robin slot scheduler.
// Sequences load, scan and finish steps of the datapath; depends on rrss_pkg.
module rrss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  rrss_pkg::ctrl_stat_t stat,
  output rrss_pkg::ctrl_cmd_t  cmd,
  output logic               busy
);
  import rrss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_CREATE || op == OP_CHOOSE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load   = accept;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = (state == S_FINISH);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && (stat.hit || stat.last) |=> (state == S_FINISH))
    else $error("scan did not end on hit or last slot");

  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (state == S_IDLE))
    else $error("finish step lasted more than one cycle");

endmodule

/* design/rrss_dpath.sv */
// Datapath of the round-robin slot scheduler: slot table, active register,
// scan counter and result registers. Depends on rrss_pkg.
module rrss_dpath #(
  parameter int SLOT_COUNT = rrss_pkg::SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rrss_pkg::ctrl_cmd_t  cmd,
  input  logic [1:0]           op,
  input  logic [3:0]           target_slot,
  input  logic                 target_none,
  output rrss_pkg::ctrl_stat_t stat,
  output logic                 done,
  output logic [3:0]           slot_index,
  output logic                 slot_valid
);
  import rrss_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_ALL  = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_REST = CNT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [6:0]       COUNT7   = 7'(SLOT_COUNT);

  logic [1:0]       status [SLOT_COUNT];
  logic [IDX_W-1:0] active_idx;
  logic             active_present;

  logic [1:0]       op_q;
  logic [3:0]       target_q;
  logic             none_q;
  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_left;
  logic             found;
  logic [IDX_W-1:0] found_idx;

  logic             match;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] after_active;
  logic [IDX_W+3:0] tgt_ext;
  logic [IDX_W-1:0] tgt_idx;
  logic             tgt_ok;
  logic             same;
  logic             res_valid;
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W+3:0] res_ext;
  logic [SLOT_COUNT-1:0] is_active;

  assign next_idx     = (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
  assign after_active = (active_idx == LAST_IDX) ? '0 : active_idx + 1'b1;

  always_comb begin
    if (op_q == OP_CREATE) begin
      match = (status[scan_idx] == ST_EMPTY);
    end else begin
      match = (status[scan_idx] == ST_READY);
    end
  end

  assign stat.hit  = match;
  assign stat.last = (scan_left == CNT_ONE);

  assign tgt_ext = {{IDX_W{1'b0}}, target_q};
  assign tgt_idx = tgt_ext[IDX_W-1:0];
  assign tgt_ok  = ({3'b000, target_q} < COUNT7);

  always_comb begin
    if (none_q) begin
      same = !active_present;
    end else begin
      same = active_present && (active_idx == tgt_idx);
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res_idx   = '0;
    case (op_q)
      OP_CREATE: begin
        res_valid = found;
        res_idx   = found_idx;
      end
      OP_CHOOSE: begin
        if (found) begin
          res_valid = 1'b1;
          res_idx   = found_idx;
        end else begin
          res_valid = active_present;
          res_idx   = active_idx;
        end
      end
      OP_ACTIVATE: begin
        if (!none_q && !tgt_ok) begin
          res_valid = active_present;
          res_idx   = active_idx;
        end else if (none_q) begin
          res_valid = 1'b0;
        end else begin
          res_valid = 1'b1;
          res_idx   = tgt_idx;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res_ext = {4'b0000, res_idx};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op;
      target_q <= target_slot;
      none_q   <= target_none;
      if (op == OP_CHOOSE && active_present) begin
        scan_idx  <= after_active;
        scan_left <= CNT_REST;
      end else begin
        scan_idx  <= '0;
        scan_left <= CNT_ALL;
      end
    end else if (cmd.scan) begin
      scan_idx  <= next_idx;
      scan_left <= scan_left - 1'b1;
    end
    if (cmd.scan && match) begin
      found_idx <= scan_idx;
    end
    if (cmd.finish) begin
      slot_valid <= res_valid;
      slot_index <= res_valid ? res_ext[3:0] : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status[i] <= ST_EMPTY;
      end
      active_idx     <= '0;
      active_present <= 1'b0;
      found          <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (cmd.scan && match) begin
        found <= 1'b1;
      end
      if (cmd.finish) begin
        if (op_q == OP_CREATE && found) begin
          status[found_idx] <= ST_READY;
        end
        if (op_q == OP_ACTIVATE && (none_q || tgt_ok) && !same) begin
          if (active_present) begin
            status[active_idx] <= ST_READY;
          end
          if (none_q) begin
            active_present <= 1'b0;
            active_idx     <= '0;
          end else begin
            status[tgt_idx] <= ST_ACTIVE;
            active_present  <= 1'b1;
            active_idx      <= tgt_idx;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      is_active[i] = (status[i] == ST_ACTIVE);
    end
  end

  a_one_active: assert property (@(posedge clk) disable iff (rst)
    $countones(is_active) <= 1)
    else $error("more than one slot is active");

  a_active_marked: assert property (@(posedge clk) disable iff (rst)
    active_present |-> (status[active_idx] == ST_ACTIVE))
    else $error("active register names a slot not marked active");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !slot_valid |-> (slot_index == 4'd0))
    else $error("invalid result word carries a nonzero index");

endmodule

/* design/round_robin_slot_scheduler.sv */
// Round-robin slot scheduler: create, choose and activate over a slot table.
// Create and choose scan one slot per cycle, and hold busy through the scan and
// the finish step; at most SLOT_COUNT slots are tested. Activate and the
// unused code hold busy for the finish step only. done pulses for one cycle as busy
// falls and carries the result word. Synchronous reset empties every
// slot and clears the active register; the block is ready the cycle after reset.
module round_robin_slot_scheduler #(
  parameter int SLOT_COUNT = rrss_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [3:0] target_slot,
  input  logic       target_none,
  output logic       done,
  output logic [3:0] slot_index,
  output logic       slot_valid
);
  import rrss_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rrss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rrss_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .target_slot (target_slot),
    .target_none (target_none),
    .stat        (stat),
    .done        (done),
    .slot_index  (slot_index),
    .slot_valid  (slot_valid)
  );

endmodule

/* verif/rrss_checker.sv */
`timescale 1ns / 100ps
// Checker for the round-robin slot scheduler: predicts every result word from its own
// copy of the slot table and active register, then compares the words in order.
// Depends on rrss_pkg for the operation and slot status codes.
module rrss_checker #(
  parameter int SLOT_COUNT = rrss_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  target_slot,
  input  logic        target_none,
  input  logic        done,
  input  logic [3:0]  slot_index,
  input  logic        slot_valid,
  output int unsigned fail_count,
  output int unsigned pending
);
  import rrss_pkg::*;

  typedef struct packed {
    logic [3:0] index;
    logic       valid;
  } slot_word_t;

  logic [1:0]  slot_state [SLOT_COUNT];
  int unsigned active_slot;
  logic        active_on;
  slot_word_t  expected_words [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic slot_word_t make_word(logic valid, int unsigned idx);
    slot_word_t w;
    w.valid = valid;
    w.index = valid ? idx[3:0] : 4'd0;
    return w;
  endfunction

  function automatic slot_word_t schedule_word(logic [1:0] w_op, logic [3:0] w_slot,
                                               logic w_none);
    int unsigned base;
    int unsigned pos;
    logic        same;
    case (w_op)
      OP_CREATE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_state[i] == ST_EMPTY) begin
            slot_state[i] = ST_READY;
            return make_word(1'b1, i);
          end
        end
        return make_word(1'b0, 0);
      end
      OP_CHOOSE: begin
        base = active_on ? active_slot : 0;
        if (!active_on && slot_state[0] == ST_READY) begin
          return make_word(1'b1, 0);
        end
        for (int k = 1; k < SLOT_COUNT; k++) begin
          pos = (base + k) % SLOT_COUNT;
          if (slot_state[pos] == ST_READY) begin
            return make_word(1'b1, pos);
          end
        end
        return make_word(active_on, active_slot);
      end
      OP_ACTIVATE: begin
        if (!w_none && w_slot >= SLOT_COUNT) begin
          return make_word(active_on, active_slot);
        end
        same = w_none ? !active_on : (active_on && active_slot == w_slot);
        if (!same) begin
          if (active_on) begin
            slot_state[active_slot] = ST_READY;
          end
          if (w_none) begin
            active_on = 1'b0;
            active_slot = 0;
          end else begin
            slot_state[w_slot] = ST_ACTIVE;
            active_on = 1'b1;
            active_slot = w_slot;
          end
        end
        return make_word(active_on, active_slot);
      end
      default: begin
        return make_word(1'b0, 0);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [3:0] got, logic [3:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    slot_word_t got;
    slot_word_t want;
    if (rst) begin
      foreach (slot_state[i]) begin
        slot_state[i] = ST_EMPTY;
      end
      active_slot = 0;
      active_on = 1'b0;
      expected_words.delete();
    end else begin
      if (done) begin
        got.index = slot_index;
        got.valid = slot_valid;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with none expected", got.index, 4'd0);
        end else begin
          want = expected_words.pop_front();
          if (got.index !== want.index) begin
            report_mismatch("slot_index", got.index, want.index);
          end
          if (got.valid !== want.valid) begin
            report_mismatch("slot_valid", {3'd0, got.valid}, {3'd0, want.valid});
          end
        end
      end
      if (start && !busy) begin
        expected_words.push_back(schedule_word(op, target_slot, target_none));
      end
    end
    pending = expected_words.size();
  end

endmodule

/* verif/tb_round_robin_slot_scheduler.sv */
`timescale 1ns / 100ps
// Testbench top for the round-robin slot scheduler: drives directed and random
// command words under several idle patterns and gives the verdict.
// Depends on rrss_pkg, round_robin_slot_scheduler and rrss_checker.
module tb_round_robin_slot_scheduler;
  import rrss_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_WORDS = 260;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  op = OP_CREATE;
  logic [3:0]  target_slot = 4'd0;
  logic        target_none = 1'b0;
  logic        busy;
  logic        done;
  logic [3:0]  slot_index;
  logic        slot_valid;
  int unsigned fail_count;
  int unsigned pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  round_robin_slot_scheduler i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .target_slot (target_slot),
    .target_none (target_none),
    .done        (done),
    .slot_index  (slot_index),
    .slot_valid  (slot_valid)
  );

  rrss_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .target_slot (target_slot),
    .target_none (target_none),
    .done        (done),
    .slot_index  (slot_index),
    .slot_valid  (slot_valid),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] w_op, input logic [3:0] w_slot,
                           input logic w_none);
    logic free;
    start = 1'b1;
    op = w_op;
    target_slot = w_slot;
    target_none = w_none;
    do begin
      free = !busy;
      @(posedge clk);
      @(negedge clk);
    end while (!free);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int          idle_pct [4] = '{0, 70, 0, 7};
    int unsigned r;
    logic [1:0]  w_op;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd0, 1'b1);
    send_word(OP_UNUSED, 4'd15, 1'b1);
    send_word(OP_ACTIVATE, 4'd7, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd0, 1'b1);
    send_word(OP_CREATE, 4'd0, 1'b0);
    send_word(OP_CREATE, 4'd15, 1'b1);
    send_word(OP_CREATE, 4'd0, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd1, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd1, 1'b0);
    send_word(OP_ACTIVATE, 4'd15, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd0, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd15, 1'b1);
    send_word(OP_CREATE, 4'd0, 1'b0);
    send_word(OP_ACTIVATE, 4'd3, 1'b0);
    send_word(OP_CHOOSE, 4'd0, 1'b0);
    drain();

    foreach (idle_pct[p]) begin
      repeat (PHASE_WORDS) begin
        while ($urandom_range(99) < idle_pct[p]) begin
          start = 1'b0;
          op = 2'($urandom);
          target_slot = 4'($urandom);
          target_none = 1'($urandom);
          @(negedge clk);
        end
        r = $urandom_range(99);
        if (r < 6) begin
          w_op = OP_CREATE;
        end else if (r < 46) begin
          w_op = OP_CHOOSE;
        end else if (r < 94) begin
          w_op = OP_ACTIVATE;
        end else begin
          w_op = OP_UNUSED;
        end
        send_word(w_op, 4'($urandom_range(15)), $urandom_range(99) < 15);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
